[src/pcd_pkg.sv]
package pcd_pkg;

   localparam int NUM_PAGES_DEF = 16;
   localparam int CMD_W         = 3;
   localparam int INODE_W       = 32;
   localparam int PAGE_W        = 52;
   localparam int STATUS_W      = 3;
   localparam int SLOT_W        = 4;
   localparam int REQ_TDATA_W   = 88;
   localparam int RSP_TDATA_W   = 96;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ     = 3'd0,
      CMD_WRITE    = 3'd1,
      CMD_MAP      = 3'd2,
      CMD_WB_INODE = 3'd3,
      CMD_WB_ALL   = 3'd4,
      CMD_INVAL    = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_HIT       = 3'd0,
      STS_MISS      = 3'd1,
      STS_NO_ROOM   = 3'd2,
      STS_WB_ENTRY  = 3'd3,
      STS_NO_DIRTY  = 3'd4,
      STS_INVAL     = 3'd5
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic compare;
      logic lookup;
      logic wb_step;
      logic inv_drop;
      logic inv_done;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [CMD_W-1:0] cmd_kind;
      logic             out_free;
      logic             work_empty;
      logic             work_last;
   } ctrl_stat_type;

endpackage

[src/page_cache_directory_top.sv]
// Page cache directory: a fully associative set of NUM_PAGES slots tagged by
// (inode, page number) with FIFO replacement. Read, write and map look a page
// up and return one transaction (hit, miss with allocated slot, or no room);
// writeback returns one transaction per dirty slot in slot order, or one
// "nothing dirty"; invalidate returns one. Commands 6 and 7 produce nothing.
// A lookup passes through capture, parallel tag compare and victim pick, and
// update and load of the result. Writeback spends capture and compare and
// then emits one slot per cycle while the output register is free.
// Invalidate drops one slot per cycle and then loads its single result.
// Every cycle that loads a result also waits until the output register is
// free. Results sit in an output register, and a new request is taken as
// soon as the previous one has loaded its last result, even while that
// result still waits for rsp_tready.
module page_cache_directory_top #(
   parameter int NUM_PAGES = pcd_pkg::NUM_PAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // command[2:0], inode[34:3], page_number[86:35], zero fill
   input  logic [pcd_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status[2:0], slot[6:3], out_inode[38:7], out_page[90:39], zero fill
   output logic [pcd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import pcd_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;
   logic [INODE_W-1:0]  out_inode;
   logic [PAGE_W-1:0]   out_page;

   pcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pcd_datapath #(.NUM_PAGES(NUM_PAGES)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_tdata[CMD_W-1:0]),
      .req_inode       (req_tdata[CMD_W+INODE_W-1:CMD_W]),
      .req_page_number (req_tdata[CMD_W+INODE_W+PAGE_W-1:CMD_W+INODE_W]),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_status      (status),
      .rsp_slot        (slot),
      .rsp_out_inode   (out_inode),
      .rsp_out_page    (out_page),
      .rsp_last        (rsp_tlast)
   );

   // pack result fields, lowest first, zero fill to whole bytes
   assign rsp_tdata = {5'd0, out_page, out_inode, slot, status};

endmodule

[src/pcd_ctrl.sv]
module pcd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  pcd_pkg::ctrl_stat_type stat,
   output pcd_pkg::ctrl_cmd_type  cmd
);
   import pcd_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CMP    = 5'b00010,
      ST_LOOKUP = 5'b00100,
      ST_WB     = 5'b01000,
      ST_INV    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
            unique case (stat.cmd_kind) inside
               CMD_READ, CMD_WRITE, CMD_MAP: state_in = ST_LOOKUP;
               CMD_WB_INODE, CMD_WB_ALL:     state_in = ST_WB;
               CMD_INVAL:                    state_in = ST_INV;
               default:                      state_in = ST_IDLE;
            endcase
         end
         ST_LOOKUP: begin
            cmd.lookup = stat.out_free;
            if (stat.out_free) state_in = ST_IDLE;
         end
         ST_WB: begin
            cmd.wb_step = stat.out_free;
            if (stat.out_free && (stat.work_empty || stat.work_last)) state_in = ST_IDLE;
         end
         ST_INV: begin
            if (!stat.work_empty) begin
               cmd.inv_drop = 1'b1;
            end else if (stat.out_free) begin
               cmd.inv_done = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

[src/pcd_datapath.sv]
module pcd_datapath #(
   parameter int NUM_PAGES = pcd_pkg::NUM_PAGES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [pcd_pkg::CMD_W-1:0]      req_command,
   input  logic [pcd_pkg::INODE_W-1:0]    req_inode,
   input  logic [pcd_pkg::PAGE_W-1:0]     req_page_number,
   input  pcd_pkg::ctrl_cmd_type          cmd,
   output pcd_pkg::ctrl_stat_type         stat,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [pcd_pkg::STATUS_W-1:0]   rsp_status,
   output logic [pcd_pkg::SLOT_W-1:0]     rsp_slot,
   output logic [pcd_pkg::INODE_W-1:0]    rsp_out_inode,
   output logic [pcd_pkg::PAGE_W-1:0]     rsp_out_page,
   output logic                           rsp_last
);
   import pcd_pkg::*;

   localparam int IW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

   logic [CMD_W-1:0]   req_cmd_ff;
   logic [INODE_W-1:0] req_inode_ff;
   logic [PAGE_W-1:0]  req_page_ff;

   logic [NUM_PAGES-1:0] valid_ff, valid_in, dirty_ff, dirty_in;
   logic [IW-1:0]        age_ff [NUM_PAGES];
   logic [IW-1:0]        age_in [NUM_PAGES];
   logic [INODE_W-1:0]   tag_inode_ff [NUM_PAGES];
   logic [PAGE_W-1:0]    tag_page_ff  [NUM_PAGES];

   logic [NUM_PAGES-1:0] hit_ff, free_ff, victim_ff, work_ff, work_in;
   logic [NUM_PAGES-1:0] match_vec, inode_vec, clean_vec, victim_vec, work_vec;
   logic [NUM_PAGES-1:0] work_rest;

   logic                 rsp_valid_ff, rsp_valid_in, rsp_last_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic [INODE_W-1:0]   rsp_inode_ff;
   logic [PAGE_W-1:0]    rsp_page_ff;

   logic [IW-1:0] hit_idx, free_idx, vict_idx, work_idx, sel_idx;
   logic          alloc, evict, no_room, load;
   logic [INODE_W-1:0]  drop_inode_unused;

   function automatic logic [IW-1:0] first_idx(input logic [NUM_PAGES-1:0] v);
      logic [IW-1:0] idx;
      idx = '0;
      for (int i = NUM_PAGES - 1; i >= 0; i--) begin
         if (v[i]) idx = IW'(i);
      end
      return idx;
   endfunction

   // match vectors against the captured request
   always_comb begin
      for (int i = 0; i < NUM_PAGES; i++) begin
         inode_vec[i] = valid_ff[i] && (tag_inode_ff[i] == req_inode_ff);
         match_vec[i] = inode_vec[i] && (tag_page_ff[i] == req_page_ff);
         clean_vec[i] = valid_ff[i] && !dirty_ff[i];
      end
      for (int i = 0; i < NUM_PAGES; i++) begin
         victim_vec[i] = clean_vec[i];
         for (int j = 0; j < NUM_PAGES; j++) begin
            if (clean_vec[j] && (age_ff[j] > age_ff[i])) victim_vec[i] = 1'b0;
         end
      end
      if (req_cmd_ff == CMD_INVAL)         work_vec = inode_vec;
      else if (req_cmd_ff == CMD_WB_INODE) work_vec = inode_vec & dirty_ff;
      else                                 work_vec = valid_ff & dirty_ff;
   end

   assign hit_idx   = first_idx(hit_ff);
   assign free_idx  = first_idx(free_ff);
   assign vict_idx  = first_idx(victim_ff);
   assign work_idx  = first_idx(work_ff);
   assign work_rest = work_ff & (work_ff - 1'b1);

   assign alloc   = (hit_ff == '0) && (free_ff != '0);
   assign evict   = (hit_ff == '0) && (free_ff == '0) && (victim_ff != '0);
   assign no_room = (hit_ff == '0) && (free_ff == '0) && (victim_ff == '0);
   assign sel_idx = (hit_ff != '0) ? hit_idx : (alloc ? free_idx : vict_idx);
   assign drop_inode_unused = '0;

   // slot state next values
   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      work_in  = work_ff;
      for (int i = 0; i < NUM_PAGES; i++) age_in[i] = age_ff[i];
      if (cmd.compare) work_in = work_vec;
      if (cmd.lookup && !no_room) begin
         if (alloc || evict) begin
            for (int i = 0; i < NUM_PAGES; i++) begin
               if (valid_ff[i] && !(evict && IW'(i) == vict_idx)) begin
                  if (evict && (age_ff[i] > age_ff[vict_idx])) age_in[i] = age_ff[i];
                  else                                         age_in[i] = age_ff[i] + 1'b1;
               end
            end
            valid_in[sel_idx] = 1'b1;
            dirty_in[sel_idx] = 1'b0;
            age_in[sel_idx]   = '0;
         end
         if (req_cmd_ff == CMD_WRITE) dirty_in[sel_idx] = 1'b1;
      end
      if (cmd.wb_step && (work_ff != '0)) begin
         dirty_in[work_idx] = 1'b0;
         work_in            = work_rest;
      end
      if (cmd.inv_drop) begin
         for (int i = 0; i < NUM_PAGES; i++) begin
            if (valid_ff[i] && (age_ff[i] > age_ff[work_idx])) age_in[i] = age_ff[i] - 1'b1;
         end
         valid_in[work_idx] = 1'b0;
         dirty_in[work_idx] = 1'b0;
         age_in[work_idx]   = '0;
         work_in            = work_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         dirty_ff  <= '0;
         hit_ff    <= '0;
         free_ff   <= '0;
         victim_ff <= '0;
         work_ff   <= '0;
         for (int i = 0; i < NUM_PAGES; i++) age_ff[i] <= '0;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         work_ff  <= work_in;
         for (int i = 0; i < NUM_PAGES; i++) age_ff[i] <= age_in[i];
         if (cmd.compare) begin
            hit_ff    <= match_vec;
            free_ff   <= ~valid_ff;
            victim_ff <= victim_vec;
         end
      end
   end

   // tags and captured request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_cmd_ff   <= req_command;
         req_inode_ff <= req_inode;
         req_page_ff  <= req_page_number;
      end
      if (cmd.lookup && (alloc || evict)) begin
         tag_inode_ff[sel_idx] <= req_inode_ff;
         tag_page_ff[sel_idx]  <= req_page_ff;
      end
   end

   // output register
   assign load         = cmd.lookup || cmd.wb_step || cmd.inv_done;
   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         rsp_last_ff <= 1'b1;
         if (no_room) begin
            rsp_status_ff <= STS_NO_ROOM;
            rsp_slot_ff   <= '0;
            rsp_inode_ff  <= '0;
            rsp_page_ff   <= '0;
         end else begin
            rsp_status_ff <= (hit_ff != '0) ? STS_HIT : STS_MISS;
            rsp_slot_ff   <= SLOT_W'(sel_idx);
            rsp_inode_ff  <= req_inode_ff;
            rsp_page_ff   <= req_page_ff;
         end
      end else if (cmd.wb_step) begin
         if (work_ff == '0) begin
            rsp_status_ff <= STS_NO_DIRTY;
            rsp_slot_ff   <= '0;
            rsp_inode_ff  <= '0;
            rsp_page_ff   <= '0;
            rsp_last_ff   <= 1'b1;
         end else begin
            rsp_status_ff <= STS_WB_ENTRY;
            rsp_slot_ff   <= SLOT_W'(work_idx);
            rsp_inode_ff  <= tag_inode_ff[work_idx];
            rsp_page_ff   <= tag_page_ff[work_idx];
            rsp_last_ff   <= (work_rest == '0);
         end
      end else if (cmd.inv_done) begin
         rsp_status_ff <= STS_INVAL;
         rsp_slot_ff   <= '0;
         rsp_inode_ff  <= req_inode_ff | drop_inode_unused;
         rsp_page_ff   <= '0;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_out_inode = rsp_inode_ff;
   assign rsp_out_page  = rsp_page_ff;
   assign rsp_last      = rsp_last_ff;

   assign stat.cmd_kind   = req_cmd_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;
   assign stat.work_empty = (work_ff == '0);
   assign stat.work_last  = (work_rest == '0);

   a_dirty_valid: assert property (@(posedge clock) disable iff (reset)
      (dirty_ff & ~valid_ff) == '0) else $error("dirty slot not valid");
   a_hit_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_ff)) else $error("duplicate tag hit");
   a_victim_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(victim_ff)) else $error("several victims");
   a_wb_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.wb_step |=> rsp_valid_ff) else $error("writeback step lost result");

endmodule

[dv/tb_page_cache_directory_top.sv]
`timescale 1ns / 1ps

module tb_page_cache_directory_top;
   import pcd_pkg::*;

   localparam int SLOTS = 16;

   // One expected response transaction
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [INODE_W-1:0]  inode;
      logic [PAGE_W-1:0]   page;
      logic                last;
   } dir_rsp_type;

   // Directory shadow and queue of pending responses
   class dir_scoreboard;
      bit                 valid_q[SLOTS];
      bit                 dirty_q[SLOTS];
      logic [INODE_W-1:0] ino_q[SLOTS];
      logic [PAGE_W-1:0]  pg_q[SLOTS];
      int                 age_q[SLOTS];
      dir_rsp_type        pending[$];
      int                 errors;
      int                 checked;

      function void evict(int s);
         for (int i = 0; i < SLOTS; i++)
            if (i != s && valid_q[i] && age_q[i] > age_q[s]) age_q[i]--;
         valid_q[s] = 0; dirty_q[s] = 0; age_q[s] = 0;
      endfunction

      function void install(int s, logic [INODE_W-1:0] ino, logic [PAGE_W-1:0] pg);
         for (int i = 0; i < SLOTS; i++) if (valid_q[i]) age_q[i]++;
         valid_q[s] = 1; dirty_q[s] = 0; age_q[s] = 0;
         ino_q[s] = ino; pg_q[s] = pg;
      endfunction

      function void push(status_type st, int s, logic [INODE_W-1:0] ino,
                         logic [PAGE_W-1:0] pg, bit lst);
         dir_rsp_type r;
         r.status = st; r.slot = s[SLOT_W-1:0]; r.inode = ino; r.page = pg; r.last = lst;
         pending.push_back(r);
      endfunction

      // Note an accepted request and queue the responses it causes
      function void note_request(logic [2:0] cmd, logic [INODE_W-1:0] ino,
                                 logic [PAGE_W-1:0] pg);
         int s;
         int best;
         int n;
         status_type st;
         s = -1; best = -1; n = 0;
         if (cmd == CMD_READ || cmd == CMD_WRITE || cmd == CMD_MAP) begin
            for (int i = 0; i < SLOTS && s < 0; i++)
               if (valid_q[i] && ino_q[i] == ino && pg_q[i] == pg) s = i;
            if (s >= 0) begin
               st = STS_HIT;
            end else begin
               for (int i = 0; i < SLOTS && s < 0; i++) if (!valid_q[i]) s = i;
               if (s < 0) begin
                  for (int i = 0; i < SLOTS; i++)
                     if (valid_q[i] && !dirty_q[i] && age_q[i] > best) begin
                        best = age_q[i]; s = i;
                     end
                  if (s < 0) begin
                     push(STS_NO_ROOM, 0, '0, '0, 1);
                     return;
                  end
                  evict(s);
               end
               install(s, ino, pg);
               st = STS_MISS;
            end
            if (cmd == CMD_WRITE) dirty_q[s] = 1;
            push(st, s, ino_q[s], pg_q[s], 1);
         end else if (cmd == CMD_WB_INODE || cmd == CMD_WB_ALL) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (valid_q[i] && dirty_q[i] && (cmd == CMD_WB_ALL || ino_q[i] == ino)) begin
                  dirty_q[i] = 0;
                  push(STS_WB_ENTRY, i, ino_q[i], pg_q[i], 0);
                  n++;
               end
            end
            if (n == 0) push(STS_NO_DIRTY, 0, '0, '0, 1);
            else pending[$].last = 1;
         end else if (cmd == CMD_INVAL) begin
            for (int i = 0; i < SLOTS; i++)
               if (valid_q[i] && ino_q[i] == ino) evict(i);
            push(STS_INVAL, 0, ino, '0, 1);
         end
      endfunction

      // Compare one accepted response with the oldest expectation
      function void check_response(logic [RSP_TDATA_W-1:0] d, logic lst);
         dir_rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response exp none act data=%h last=%b", $realtime, d, lst);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (d[2:0] !== e.status) begin
            $display("%0t: status mismatch exp %0d act %0d", $realtime, e.status, d[2:0]);
            errors++;
         end
         if (d[6:3] !== e.slot) begin
            $display("%0t: slot mismatch exp %0d act %0d", $realtime, e.slot, d[6:3]);
            errors++;
         end
         if (d[38:7] !== e.inode) begin
            $display("%0t: inode mismatch exp %h act %h", $realtime, e.inode, d[38:7]);
            errors++;
         end
         if (d[90:39] !== e.page) begin
            $display("%0t: page mismatch exp %h act %h", $realtime, e.page, d[90:39]);
            errors++;
         end
         if (lst !== e.last) begin
            $display("%0t: last mismatch exp %b act %b", $realtime, e.last, lst);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_tvalid = 0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   dir_scoreboard dir_sb;
   int            cycles = 0;
   bit            hold_off = 0;
   int            sent = 0;

   // Pool of inodes and pages kept small so hits, evictions and writebacks recur
   logic [INODE_W-1:0] ino_pool[4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001};
   logic [PAGE_W-1:0]  pg_pool[4]  = '{52'h0, 52'hF_FFFF_FFFF_FFFF, 52'h1, 52'h8_0000_0000_0000};

   always #4 clock = ~clock;

   page_cache_directory_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   // Offer one transaction and hold it until the handshake completes
   task automatic send_cmd(logic [2:0] cmd, logic [INODE_W-1:0] ino, logic [PAGE_W-1:0] pg);
      req_tvalid <= 1;
      req_tdata  <= {1'b0, pg, ino, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      dir_sb.note_request(cmd, ino, pg);
      sent++;
   endtask

   // Drop valid and wait out a random gap
   task automatic idle_gap(int n);
      req_tvalid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_random();
      int k;
      logic [2:0] cmd;
      logic [INODE_W-1:0] ino;
      logic [PAGE_W-1:0] pg;
      k = $urandom_range(0, 99);
      // Mostly lookups on a reused pool; some commands with fresh values and unknown codes
      if (k < 30) cmd = CMD_READ;
      else if (k < 60) cmd = CMD_WRITE;
      else if (k < 72) cmd = CMD_MAP;
      else if (k < 80) cmd = CMD_WB_INODE;
      else if (k < 86) cmd = CMD_WB_ALL;
      else if (k < 93) cmd = CMD_INVAL;
      else cmd = 3'($urandom_range(6, 7));
      ino = ($urandom_range(0, 4) == 0) ? $urandom() : ino_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 4) == 0) pg = 52'({$urandom(), $urandom()});
      else pg = pg_pool[$urandom_range(0, 3)] ^ 52'($urandom_range(0, 5));
      send_cmd(cmd, ino, pg);
   endtask

   // Receiver: own stall pattern, plus a long hold-off on request
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         if (hold_off) rsp_tready <= 0;
         else if (phase % 64 < 20) rsp_tready <= 1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Check each accepted response transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) dir_sb.check_response(rsp_tdata, rsp_tlast);
   end

   // Watchdog on the cycle count
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Long receiver stall while the sender keeps offering
   initial begin
      wait (sent >= 60);
      hold_off = 1;
      repeat (300) @(posedge clock);
      hold_off = 0;
   end

   initial begin
      dir_sb = new();
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty writeback, fill all slots with writes (extreme tags)
      send_cmd(CMD_WB_ALL, '0, '0);
      send_cmd(CMD_WB_INODE, '1, '0);
      for (int i = 0; i < SLOTS; i++)
         send_cmd(CMD_WRITE, (i % 2) ? 32'hFFFF_FFFF : 32'h0,
                  (i == 15) ? 52'hF_FFFF_FFFF_FFFF : 52'(i));
      // Every slot dirty: a miss has no room
      send_cmd(CMD_READ, 32'h5, 52'h5);
      send_cmd(CMD_MAP, 32'h0, 52'h0);                  // hit
      send_cmd(CMD_WB_INODE, 32'hFFFF_FFFF, '0);        // eight results
      send_cmd(CMD_READ, 32'h5, 52'h5);                 // evicts oldest clean
      send_cmd(CMD_WB_ALL, '0, '0);                     // full walk
      send_cmd(3'd6, 32'h1, 52'h1);                     // ignored
      send_cmd(3'd7, 32'h1, 52'h1);                     // ignored
      send_cmd(CMD_INVAL, 32'h0, '0);
      send_cmd(CMD_INVAL, 32'hFFFF_FFFF, '0);

      // Random part in bursts with gaps
      while (sent < 220) begin
         repeat ($urandom_range(1, 12)) send_random();
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
      end
      req_tvalid <= 0;

      while (dir_sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Covered %0d requests and %0d response transactions, incl. no-room,",
               sent, dir_sb.checked);
      $display("eviction, writeback walks, invalidate and unknown commands.");
      if (dir_sb.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

[page_cache_directory_top.f]
src/pcd_pkg.sv
src/pcd_ctrl.sv
src/pcd_datapath.sv
src/page_cache_directory_top.sv
dv/tb_page_cache_directory_top.sv
